// ----- src/uidq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uidq_pkg: shared types for the unique id ordered queue
// Operation and status codes, and the control bundle sent to every cell.
// ----------------------------------------------------------------------------
package uidq_pkg;

    typedef enum logic [2:0] {
        OP_INS_HEAD = 3'd0,
        OP_INS_TAIL = 3'd1,
        OP_REMOVE   = 3'd2,
        OP_DEQUEUE  = 3'd3,
        OP_SEARCH   = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_DUP   = 3'd1,
        ST_FULL  = 3'd2,
        ST_MISS  = 3'd3,
        ST_EMPTY = 3'd4
    } t_status;

    // Per-cycle command broadcast along the row of cells
    typedef struct packed {
        logic ins_head;   // shift toward the tail, cell 0 takes the new id
        logic ins_tail;   // cell at the fill position takes the new id
        logic del;        // close up from the hit position toward the head
        logic rm_cmp;     // a compare hit marks the removal position
    } t_cell_ctl;

endpackage

// ----- src/uidq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uidq_cell: one queue slot
// Holds one identifier, compares it with the broadcast id and passes match
// and removal-position flags and the matched value on to the next cell toward the tail.
// ----------------------------------------------------------------------------
module uidq_cell #(
    parameter int W   = 16,
    parameter int CW  = 5,
    parameter int IDX = 0
) (
    input  logic             i_clk,
    input  uidq_pkg::t_cell_ctl i_ctl,
    input  logic [W-1:0]     i_id,
    input  logic [CW-1:0]    i_count,
    input  logic [W-1:0]     i_prev_entry,
    input  logic [W-1:0]     i_next_entry,
    input  logic             i_hit,
    input  logic             i_any,
    input  logic [W-1:0]     i_val,
    output logic [W-1:0]     o_entry,
    output logic             o_hit,
    output logic             o_any,
    output logic [W-1:0]     o_val
);
    import uidq_pkg::*;

    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    logic [W-1:0] r_entry;
    logic [W-1:0] n_entry;
    logic         w_valid;
    logic         w_match;
    logic         w_hit;

    assign w_valid = (IDX_C < i_count);
    assign w_match = w_valid && (r_entry == i_id);
    assign w_hit   = i_hit || (i_ctl.rm_cmp && w_match);

    assign o_hit   = w_hit;
    assign o_any   = i_any || w_match;
    // ids are unique, so at most one cell contributes its value
    assign o_val   = i_val | (w_match ? r_entry : '0);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        priority if (i_ctl.ins_head) begin
            n_entry = i_prev_entry;
        end else if (i_ctl.ins_tail && (i_count == IDX_C)) begin
            n_entry = i_id;
        end else if (i_ctl.del && w_hit) begin
            n_entry = i_next_entry;
        end else begin
            // hold
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ----- src/unique_id_ordered_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_id_ordered_queue: ordered queue of unique task identifiers
// A row of slot cells with head insert, tail insert, remove by id, dequeue
// and search.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive i_op and i_task_id with start high; the item is
//   taken at a rising edge where start is high and busy is low. busy stays
//   low, so one item can be issued every cycle.
//   Result channel: o_status, o_found, o_out_id and o_entry_count appear in the
//   cycle after the item is taken, with o_result_valid high for exactly that
//   cycle. The receiver cannot stall; each result must be captured then.
//   Throughput is one item per cycle. Every slot compares its id with the
//   broadcast id in parallel; match, removal position and matched value
//   ripple through the cell row, and all slots shift by one place at the
//   same edge.
//   Reset (i_rst_n low, synchronous) empties the queue and drops any pending
//   result. Slot contents are not cleared; only slots below the entry count
//   are ever read.
// ----------------------------------------------------------------------------
module unique_id_ordered_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_op,
    input  logic [15:0] i_task_id,
    output logic        o_result_valid,
    output logic [2:0]  o_status,
    output logic        o_found,
    output logic [15:0] o_out_id,
    output logic [4:0]  o_entry_count
);
    import uidq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    logic [ID_BITS-1:0] w_id;
    logic [ID_BITS-1:0] w_entry [QUEUE_DEPTH];
    logic               w_hit   [QUEUE_DEPTH+1];
    logic               w_any   [QUEUE_DEPTH+1];
    logic [ID_BITS-1:0] w_val   [QUEUE_DEPTH+1];
    t_cell_ctl          w_ctl;

    logic [CW-1:0]  r_count;
    logic [CW-1:0]  n_count;
    logic           r_result_valid;
    t_status        r_status;
    t_status        n_status;
    logic           r_found;
    logic           n_found;
    logic [15:0]    r_out_id;
    logic [15:0]    n_out_id;

    logic w_accept;
    logic w_empty;
    logic w_full;
    logic w_any_match;

    assign busy        = 1'b0;
    assign w_accept    = start && !busy;
    assign w_id        = ID_BITS'(i_task_id);
    assign w_empty     = (r_count == '0);
    assign w_full      = (r_count >= DEPTH_C);
    assign w_any_match = w_any[QUEUE_DEPTH];

    assign w_hit[0] = (i_op == OP_DEQUEUE);
    assign w_any[0] = 1'b0;
    assign w_val[0] = '0;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic [ID_BITS-1:0] w_prev;
        logic [ID_BITS-1:0] w_next;

        if (g == 0) begin : g_first
            assign w_prev = w_id;
        end else begin : g_mid
            assign w_prev = w_entry[g-1];
        end
        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign w_next = w_entry[g];
        end else begin : g_body
            assign w_next = w_entry[g+1];
        end

        uidq_cell #(
            .W   (ID_BITS),
            .CW  (CW),
            .IDX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_id         (w_id),
            .i_count      (r_count),
            .i_prev_entry (w_prev),
            .i_next_entry (w_next),
            .i_hit        (w_hit[g]),
            .i_any        (w_any[g]),
            .i_val        (w_val[g]),
            .o_entry      (w_entry[g]),
            .o_hit        (w_hit[g+1]),
            .o_any        (w_any[g+1]),
            .o_val        (w_val[g+1])
        );
    end

    always_comb begin
        w_ctl    = '0;
        n_count  = r_count;
        n_status = ST_OK;
        n_found  = 1'b0;
        n_out_id = '0;
        w_ctl.rm_cmp = (i_op == OP_REMOVE);
        if (w_accept) begin
            unique case (i_op)
                OP_INS_HEAD, OP_INS_TAIL: begin
                    priority if (w_any_match) begin
                        n_status = ST_DUP;
                    end else if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        w_ctl.ins_head = (i_op == OP_INS_HEAD);
                        w_ctl.ins_tail = (i_op == OP_INS_TAIL);
                        n_count        = r_count + 1'b1;
                    end
                end
                OP_REMOVE: begin
                    priority if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else if (w_any_match) begin
                        w_ctl.del = 1'b1;
                        n_found   = 1'b1;
                        n_out_id  = 16'(w_val[QUEUE_DEPTH]);
                        n_count   = r_count - 1'b1;
                    end else begin
                        n_status = ST_MISS;
                    end
                end
                OP_DEQUEUE: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        w_ctl.del = 1'b1;
                        n_found   = 1'b1;
                        n_out_id  = 16'(w_entry[0]);
                        n_count   = r_count - 1'b1;
                    end
                end
                OP_SEARCH: begin
                    if (w_any_match) begin
                        n_found  = 1'b1;
                        n_out_id = 16'(w_val[QUEUE_DEPTH]);
                    end else begin
                        n_status = ST_MISS;
                    end
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count        <= '0;
            r_result_valid <= 1'b0;
        end else begin
            r_count        <= n_count;
            r_result_valid <= w_accept;
        end
        r_status <= n_status;
        r_found  <= n_found;
        r_out_id <= n_out_id;
    end

    assign o_result_valid = r_result_valid;
    assign o_status       = r_status;
    assign o_found        = r_found;
    assign o_out_id       = r_out_id;
    assign o_entry_count  = 5'(r_count);

endmodule
